// ===== rtl/heightmap_bilinear_sampler_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the height grid sampler
// Shared wrappers for clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_MACROS_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_MACROS_SVH

// same-cycle implication
`define HBS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hbs check failed");

// next-cycle implication
`define HBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hbs check failed");

`endif

// ===== rtl/hbs_pkg.sv =====
// ----------------------------------------------------------------------------
// hbs_pkg
// Types and constants shared by the height grid sampler modules.
// ----------------------------------------------------------------------------
package hbs_pkg;

  localparam int MAX_SIDE_DEF = 256;
  localparam int BANK_AW_DEF  = 14;

  typedef enum logic [0:0] {
    CMD_SAMPLE = 1'b0,
    CMD_WRITE  = 1'b1
  } cmd_t;

  typedef enum logic [0:0] {
    REG_CELLS_X = 1'b0,
    REG_CELLS_Y = 1'b1
  } cfg_idx_t;

  // per-item control that travels beside the bank read data
  typedef struct packed {
    logic       zero;    // force a zero height (write or outside sample)
    logic       status;
    logic       ix0;     // parity of the cell corner x
    logic       iy0;     // parity of the cell corner y
    logic [7:0] fx;
    logic [7:0] fy;
  } smp_ctl_t;

  // read data of the four banks, index {x parity, y parity}
  typedef logic [3:0][15:0] bank_q_t;

endpackage

// ===== rtl/hbs_bank.sv =====
// ----------------------------------------------------------------------------
// hbs_bank
// One height bank: single write port, one registered read port.
// ----------------------------------------------------------------------------
module hbs_bank #(
  parameter int AW = hbs_pkg::BANK_AW_DEF
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [2**AW];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/hbs_interp.sv =====
// ----------------------------------------------------------------------------
// hbs_interp
// Two-stage bilinear datapath: x blend of both rows, then y blend and round.
// ----------------------------------------------------------------------------
module hbs_interp (
  input  logic              clk,
  input  logic              ld_b,
  input  logic              ld_o,
  input  hbs_pkg::smp_ctl_t ctl_a,
  input  hbs_pkg::bank_q_t  bank_q,
  output logic [15:0]       height_out,
  output logic              status_out
);

  import hbs_pkg::*;

  logic signed [15:0] h0, h1, h2, h3;
  logic signed [9:0]  wx0, wx1, wy0, wy1;
  logic signed [25:0] p0, p1, p2, p3;
  logic signed [25:0] hx0_nxt, hx1_nxt;
  logic signed [25:0] hx0_r, hx1_r;
  logic               zero_b_r, status_b_r;
  logic [7:0]         fy_b_r;
  logic signed [35:0] q0, q1, acc, rnd;
  logic [15:0]        height_r;
  logic               status_r;

  // pick corners out of the banks by the corner parity
  always_comb begin
    h0 = signed'(bank_q[{ctl_a.ix0,  ctl_a.iy0}]);
    h1 = signed'(bank_q[{~ctl_a.ix0, ctl_a.iy0}]);
    h2 = signed'(bank_q[{ctl_a.ix0,  ~ctl_a.iy0}]);
    h3 = signed'(bank_q[{~ctl_a.ix0, ~ctl_a.iy0}]);
    wx1 = signed'({2'b00, ctl_a.fx});
    wx0 = 10'sd256 - wx1;
    p0 = h0 * wx0;
    p1 = h1 * wx1;
    p2 = h2 * wx0;
    p3 = h3 * wx1;
    hx0_nxt = p0 + p1;
    hx1_nxt = p2 + p3;
  end

  always_ff @(posedge clk) begin
    if (ld_b) begin
      hx0_r      <= hx0_nxt;
      hx1_r      <= hx1_nxt;
      zero_b_r   <= ctl_a.zero;
      status_b_r <= ctl_a.status;
      fy_b_r     <= ctl_a.fy;
    end
  end

  // y blend, then round half up on the 2^16 scale
  always_comb begin
    wy1 = signed'({2'b00, fy_b_r});
    wy0 = 10'sd256 - wy1;
    q0  = hx0_r * wy0;
    q1  = hx1_r * wy1;
    acc = q0 + q1;
    rnd = acc + 36'sd32768;
  end

  always_ff @(posedge clk) begin
    if (ld_o) begin
      height_r <= zero_b_r ? 16'd0 : rnd[31:16];
      status_r <= status_b_r;
    end
  end

  assign height_out = height_r;
  assign status_out = status_r;

endmodule

// ===== rtl/heightmap_bilinear_sampler.sv =====
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler
// Writable height grid with bilinear sampling of Q8.8 positions.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on in_*; in_tuser selects sample (0) or vertex write (1).
//   Every input word gives exactly one output word on out_*: the Q8.8 height
//   in out_tdata and the status flag in out_tuser (1 = outside or ignored).
//   Grid size is set through cfg_we/cfg_addr/cfg_wdata while the block is idle.
//   The heights sit in four banks split by vertex x/y parity, so the four
//   corners of a cell are read in one access.
// Timing:
//   A word accepted at edge T has its result valid after edge T+2 (bank read
//   at T, x blend at T+1, y blend and round at T+2). The pipeline takes one
//   word per cycle.
//   Writes commit to the bank at their acceptance edge, so later samples see
//   them without forwarding.
// Reset:
//   After reset a clearing pass zeroes the banks, 2^(2*(CW-1)) cycles
//   (16384 at MAX_SIDE 256); in_tready stays low during it.
// Stall:
//   A stalled output holds its word; the stages behind it fill, then
//   in_tready drops until out_tready returns.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler #(
  parameter int MAX_SIDE = hbs_pkg::MAX_SIDE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // pos_x[15:0], pos_y[31:16], vertex_x[39:32], vertex_y[47:40], height_in[63:48]
  input  logic [63:0] in_tdata,
  // cmd[0]
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // height_out[15:0]
  output logic [15:0] out_tdata,
  // status[0]
  output logic [0:0]  out_tuser,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  import hbs_pkg::*;

  localparam int CW = (MAX_SIDE > 4) ? $clog2(MAX_SIDE) : 2;
  localparam int HW = CW - 1;
  localparam int AW = 2 * HW;
  localparam logic [7:0] MAXC = (MAX_SIDE - 1 > 255) ? 8'd255 : 8'(MAX_SIDE - 1);

  logic [7:0]    cells_x_r, cells_y_r;
  logic [7:0]    eff_cx, eff_cy;
  logic          clearing_r;
  logic [AW-1:0] clr_addr_r;
  logic          a_v_r, b_v_r, o_v_r;
  logic          acc_in, ld_b, ld_o, free_b, free_a;
  smp_ctl_t      ctl_a_r, ctl_nxt;
  bank_q_t       bank_q;
  logic [3:0]    bank_we;
  logic [AW-1:0] bank_raddr [4];
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;

  logic [15:0]   pos_x, pos_y, height_in;
  logic [7:0]    vertex_x, vertex_y;
  logic [15:0]   ix_w, iy_w, vx_w, vy_w;
  logic [CW-1:0] ix_c, iy_c, ix1_c, iy1_c, vx_c, vy_c;
  logic          is_write, wr_bad, smp_out;

  assign pos_x     = in_tdata[15:0];
  assign pos_y     = in_tdata[31:16];
  assign vertex_x  = in_tdata[39:32];
  assign vertex_y  = in_tdata[47:40];
  assign height_in = in_tdata[63:48];

  assign eff_cx = (cells_x_r > MAXC) ? MAXC : cells_x_r;
  assign eff_cy = (cells_y_r > MAXC) ? MAXC : cells_y_r;

  assign ix_w  = {8'd0, pos_x[15:8]};
  assign iy_w  = {8'd0, pos_y[15:8]};
  assign vx_w  = {8'd0, vertex_x};
  assign vy_w  = {8'd0, vertex_y};
  assign ix_c  = ix_w[CW-1:0];
  assign iy_c  = iy_w[CW-1:0];
  assign vx_c  = vx_w[CW-1:0];
  assign vy_c  = vy_w[CW-1:0];
  assign ix1_c = ix_c + CW'(1);
  assign iy1_c = iy_c + CW'(1);

  assign is_write = (cmd_t'(in_tuser) == CMD_WRITE);
  assign wr_bad   = (vertex_x > eff_cx) || (vertex_y > eff_cy);
  assign smp_out  = (pos_x[15:8] >= eff_cx) || (pos_y[15:8] >= eff_cy);

  // pipeline flow
  assign ld_o      = b_v_r && (!o_v_r || out_tready);
  assign free_b    = !b_v_r || ld_o;
  assign ld_b      = a_v_r && free_b;
  assign free_a    = !a_v_r || ld_b;
  assign in_tready = free_a && !clearing_r;
  assign acc_in    = in_tvalid && in_tready;

  always_comb begin
    ctl_nxt.zero   = is_write || smp_out;
    ctl_nxt.status = is_write ? wr_bad : smp_out;
    ctl_nxt.ix0    = ix_c[0];
    ctl_nxt.iy0    = iy_c[0];
    ctl_nxt.fx     = pos_x[7:0];
    ctl_nxt.fy     = pos_y[7:0];
  end

  // bank {bx,by} holds the corner whose x parity is bx and y parity is by
  always_comb begin
    logic [1:0]    bi;
    logic [CW-1:0] xa, ya;
    for (int b = 0; b < 4; b++) begin
      bi = 2'(b);
      xa = (ix_c[0] == bi[1]) ? ix_c : ix1_c;
      ya = (iy_c[0] == bi[0]) ? iy_c : iy1_c;
      bank_raddr[b] = {xa[CW-1:1], ya[CW-1:1]};
      bank_we[b]    = clearing_r ||
                      (acc_in && is_write && !wr_bad && ({vx_c[0], vy_c[0]} == bi));
    end
  end

  assign waddr = clearing_r ? clr_addr_r : {vx_c[CW-1:1], vy_c[CW-1:1]};
  assign wdata = clearing_r ? 16'd0 : height_in;

  for (genvar g = 0; g < 4; g++) begin : g_bank
    hbs_bank #(
      .AW (AW)
    ) u_bank (
      .clk   (clk),
      .we    (bank_we[g]),
      .waddr (waddr),
      .wdata (wdata),
      .re    (acc_in),
      .raddr (bank_raddr[g]),
      .rdata (bank_q[g])
    );
  end

  hbs_interp u_interp (
    .clk        (clk),
    .ld_b       (ld_b),
    .ld_o       (ld_o),
    .ctl_a      (ctl_a_r),
    .bank_q     (bank_q),
    .height_out (out_tdata),
    .status_out (out_tuser[0])
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_x_r <= 8'd255;
      cells_y_r <= 8'd255;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        REG_CELLS_X: cells_x_r <= cfg_wdata;
        REG_CELLS_Y: cells_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sweep every bank entry to zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (&clr_addr_r) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (acc_in) begin
        a_v_r <= 1'b1;
      end else if (ld_b) begin
        a_v_r <= 1'b0;
      end
      if (ld_b) begin
        b_v_r <= 1'b1;
      end else if (ld_o) begin
        b_v_r <= 1'b0;
      end
      if (ld_o) begin
        o_v_r <= 1'b1;
      end else if (out_tready) begin
        o_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      ctl_a_r <= ctl_nxt;
    end
  end

  assign out_tvalid = o_v_r;

endmodule

// ===== rtl/hbs_checker.sv =====
// ----------------------------------------------------------------------------
// hbs_checker
// Port-level checks for the height grid sampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "heightmap_bilinear_sampler_macros.svh"

module hbs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // a flagged word never carries a height
  `HBS_ASSERT_NOW(a_flag_zero, out_tvalid && out_tuser[0], out_tdata == 16'd0)

  // the clearing pass holds off input right after reset
  `HBS_ASSERT_NOW(a_clear_blocks, !$past(rst_n), !in_tready)

  // no result can be pending right after reset
  `HBS_ASSERT_NOW(a_reset_empty, !$past(rst_n), !out_tvalid)

  // a stalled result holds
  `HBS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata) && $stable(out_tuser))

endmodule

bind heightmap_bilinear_sampler hbs_checker u_hbs_checker (.*);
